// ===== hw/rtl/pbba_pkg.sv =====
// shared types and constants for the per-bone bounding box accumulator
package pbba_pkg;

    localparam int BONE_COUNT     = 64;
    localparam int MAX_INFLUENCES = 4;
    localparam int INFL_FIELDS    = 4;
    localparam int BONE_W         = 6;
    localparam int COORD_W        = 32;
    localparam int WC_W           = 3;
    localparam int IDX_W          = $clog2(INFL_FIELDS + 1);
    localparam int SEL_W          = $clog2(INFL_FIELDS);
    localparam int CFG_AW         = 3;
    localparam int CFG_DW         = 32;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_ADD     = 2'd1,
        OP_RD_ALL  = 2'd2,
        OP_RD_BONE = 2'd3
    } t_op;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [BONE_W-1:0]         t_bone;

    typedef struct packed {
        logic [1:0]             op;
        t_coord                 pos_x;
        t_coord                 pos_y;
        t_coord                 pos_z;
        t_bone                  bone_a;
        t_bone                  bone_b;
        t_bone                  bone_c;
        t_bone                  bone_d;
        logic [INFL_FIELDS-1:0] weight_nonzero;
        t_bone                  read_bone;
    } t_in_item;

    typedef struct packed {
        logic   box_empty;
        t_coord min_x;
        t_coord min_y;
        t_coord min_z;
        t_coord max_x;
        t_coord max_y;
        t_coord max_z;
    } t_out_item;

    // corners as x, y, z lanes
    typedef struct packed {
        t_coord [2:0] mn;
        t_coord [2:0] mx;
    } t_box;

endpackage

// ===== hw/rtl/per_bone_bounding_box_accumulator_top.sv =====
// Per-bone bounding box accumulator: overall box plus one box per bone.
//
// An item is taken when start is high and busy is low. Ops: clear all boxes,
// add a vertex, read the overall box, read one bone's box. Read ops give one
// result, shown on o_result for exactly one cycle with o_result_valid high;
// the receiver cannot hold it off. Clear and add give no result.
// Items are run by one sequencer driving one widen unit and a box memory with
// one write port and one registered read port (read, then write back, per bone):
//   clear: done on acceptance, busy stays low
//   read overall box: result in the next cycle, busy stays low
//   read bone box: S_BRD then S_BOUT, result strobed in the cycle busy falls
//   add vertex: S_OVR widens the overall box, then S_INF examines each
//     influence in turn and S_UPD writes back each bone box updated
// Reset empties the overall box and every bone box and sets the weight count
// register to 4. The bone memory needs no clearing pass: per-bone valid bits
// mark which boxes hold data. The user must write weight count on the apb port
// only while the block is idle; the block itself does not enforce it.
module per_bone_bounding_box_accumulator_top import pbba_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_in_item          i_item,
    output logic              o_result_valid,
    output t_out_item         o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OVR,
        S_INF,
        S_UPD,
        S_BRD,
        S_BOUT
    } t_state;

    t_state                 r_state;
    t_in_item               r_item;
    logic [IDX_W-1:0]       r_idx;
    logic [IDX_W-1:0]       r_limit;
    logic [BONE_COUNT-1:0]  r_valid_bits;
    t_box                   r_ovr_box;
    logic                   r_ovr_valid;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic [WC_W-1:0]        w_weight_count;
    logic [IDX_W-1:0]       n_limit;
    t_bone                  w_bones [INFL_FIELDS];
    t_bone                  w_cur_bone;
    logic                   w_cur_en;
    t_coord [2:0]           w_pos;
    t_box                   w_wid_in;
    logic                   w_wid_valid;
    t_box                   w_wid_out;
    logic                   w_mem_we;
    t_bone                  w_raddr;
    t_box                   w_rdata;
    logic                   w_rd_bone_ok;
    logic                   w_accept;

    pbba_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_weight_count (w_weight_count)
    );

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // influences examined: weight count capped by field count and max influences
    always_comb begin
        n_limit = IDX_W'(INFL_FIELDS);
        if (MAX_INFLUENCES < INFL_FIELDS) begin
            n_limit = IDX_W'(MAX_INFLUENCES);
        end
        if (int'(w_weight_count) < int'(n_limit)) begin
            n_limit = IDX_W'(w_weight_count);
        end
    end

    assign w_bones[0] = r_item.bone_a;
    assign w_bones[1] = r_item.bone_b;
    assign w_bones[2] = r_item.bone_c;
    assign w_bones[3] = r_item.bone_d;

    assign w_cur_bone = w_bones[r_idx[SEL_W-1:0]];
    assign w_cur_en   = r_item.weight_nonzero[r_idx[SEL_W-1:0]]
                        && (int'(w_cur_bone) < BONE_COUNT);
    assign w_pos      = {r_item.pos_z, r_item.pos_y, r_item.pos_x};

    assign w_rd_bone_ok = (int'(r_item.read_bone) < BONE_COUNT)
                          && r_valid_bits[r_item.read_bone];

    // widen unit serves the overall box first, then each bone box in turn
    always_comb begin
        if (r_state == S_OVR) begin
            w_wid_in    = r_ovr_box;
            w_wid_valid = r_ovr_valid;
        end else begin
            w_wid_in    = w_rdata;
            w_wid_valid = r_valid_bits[w_cur_bone];
        end
    end

    pbba_widen u_widen (
        .i_box   (w_wid_in),
        .i_valid (w_wid_valid),
        .i_pos   (w_pos),
        .o_box   (w_wid_out)
    );

    assign w_mem_we = (r_state == S_UPD);
    assign w_raddr  = (r_state == S_BRD) ? r_item.read_bone : w_cur_bone;

    pbba_box_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_cur_bone),
        .i_wdata (w_wid_out),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid_bits <= '0;
            r_ovr_valid  <= 1'b0;
            r_ovr_box    <= '0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_item  <= i_item;
                        r_limit <= n_limit;
                        r_idx   <= '0;
                        unique case (t_op'(i_item.op))
                            OP_CLEAR: begin
                                r_valid_bits <= '0;
                                r_ovr_valid  <= 1'b0;
                            end
                            OP_ADD: begin
                                r_state <= S_OVR;
                            end
                            OP_RD_ALL: begin
                                r_out_valid     <= 1'b1;
                                r_out.box_empty <= !r_ovr_valid;
                                r_out.min_x     <= r_ovr_valid ? r_ovr_box.mn[0] : '0;
                                r_out.min_y     <= r_ovr_valid ? r_ovr_box.mn[1] : '0;
                                r_out.min_z     <= r_ovr_valid ? r_ovr_box.mn[2] : '0;
                                r_out.max_x     <= r_ovr_valid ? r_ovr_box.mx[0] : '0;
                                r_out.max_y     <= r_ovr_valid ? r_ovr_box.mx[1] : '0;
                                r_out.max_z     <= r_ovr_valid ? r_ovr_box.mx[2] : '0;
                            end
                            OP_RD_BONE: begin
                                r_state <= S_BRD;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_OVR: begin
                    r_ovr_box   <= w_wid_out;
                    r_ovr_valid <= 1'b1;
                    r_state     <= S_INF;
                end
                S_INF: begin
                    // memory read of the current bone is issued here; S_UPD uses it when the influence is live
                    if (r_idx >= r_limit) begin
                        r_state <= S_IDLE;
                    end else if (w_cur_en) begin
                        r_state <= S_UPD;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_UPD: begin
                    r_valid_bits[w_cur_bone] <= 1'b1;
                    r_idx                    <= r_idx + IDX_W'(1);
                    r_state                  <= S_INF;
                end
                S_BRD: begin
                    r_state <= S_BOUT;
                end
                S_BOUT: begin
                    r_out_valid     <= 1'b1;
                    r_out.box_empty <= !w_rd_bone_ok;
                    r_out.min_x     <= w_rd_bone_ok ? w_rdata.mn[0] : '0;
                    r_out.min_y     <= w_rd_bone_ok ? w_rdata.mn[1] : '0;
                    r_out.min_z     <= w_rd_bone_ok ? w_rdata.mn[2] : '0;
                    r_out.max_x     <= w_rd_bone_ok ? w_rdata.mx[0] : '0;
                    r_out.max_y     <= w_rd_bone_ok ? w_rdata.mx[1] : '0;
                    r_out.max_z     <= w_rd_bone_ok ? w_rdata.mx[2] : '0;
                    r_state         <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

`ifndef SYNTHESIS
    a_clear_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_item.op == OP_CLEAR) |=> !o_result_valid)
        else $error("clear produced a result");

    a_rd_all_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_item.op == OP_RD_ALL) |=> (o_result_valid && !busy))
        else $error("overall read result not given in the next cycle");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.box_empty) |->
        (o_result.min_x == '0 && o_result.min_y == '0 && o_result.min_z == '0 &&
         o_result.max_x == '0 && o_result.max_y == '0 && o_result.max_z == '0))
        else $error("empty box result has nonzero corners");

    a_add_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OVR || r_state == S_INF || r_state == S_UPD) |-> !o_result_valid)
        else $error("result strobed during vertex update");
`endif

endmodule

// ===== hw/rtl/pbba_widen.sv =====
// shared widen unit: grows one box to take in one point
module pbba_widen import pbba_pkg::*; (
    input  t_box         i_box,
    input  logic         i_valid,
    input  t_coord [2:0] i_pos,
    output t_box         o_box
);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (!i_valid) begin
                o_box.mn[k] = i_pos[k];
                o_box.mx[k] = i_pos[k];
            end else begin
                o_box.mn[k] = ($signed(i_pos[k]) < $signed(i_box.mn[k])) ? i_pos[k] : i_box.mn[k];
                o_box.mx[k] = ($signed(i_box.mx[k]) < $signed(i_pos[k])) ? i_pos[k] : i_box.mx[k];
            end
        end
    end

endmodule

// ===== hw/rtl/pbba_box_mem.sv =====
// per-bone box memory, one write port and one registered read port
module pbba_box_mem import pbba_pkg::*; (
    input  logic  i_clk,
    input  logic  i_we,
    input  t_bone i_waddr,
    input  t_box  i_wdata,
    input  t_bone i_raddr,
    output t_box  o_rdata
);

    t_box r_mem [BONE_COUNT];
    t_box r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/pbba_cfg.sv =====
// configuration register file on the apb port
module pbba_cfg import pbba_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output logic [WC_W-1:0]   o_weight_count
);

    localparam logic [CFG_AW-1:0] ADDR_WEIGHT_COUNT = CFG_AW'(0);
    localparam logic [WC_W-1:0]   WC_RESET          = WC_W'(4);

    logic [WC_W-1:0] r_weight_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_count <= WC_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_WEIGHT_COUNT) begin
            r_weight_count <= pwdata[WC_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_WEIGHT_COUNT) begin
            prdata = CFG_DW'(r_weight_count);
        end
    end

    assign pready         = 1'b1;
    assign o_weight_count = r_weight_count;

endmodule

// ===== sim/bbox_scoreboard_pkg.sv =====
// scoreboard class that predicts and checks the bounding box read results
package bbox_check_pkg;

    import pbba_pkg::*;

    class bbox_scoreboard;

        logic [WC_W-1:0] wcount;
        t_box            all_box;
        bit              all_valid;
        t_box            bone_box [BONE_COUNT];
        bit              bone_valid [BONE_COUNT];
        t_out_item       boxes_due [$];
        int unsigned     mismatches;
        int unsigned     checked;
        int unsigned     op_count [4];

        function new();
            wcount    = WC_W'(4);
            all_valid = 1'b0;
            all_box   = '0;
            foreach (bone_valid[b]) begin
                bone_valid[b] = 1'b0;
                bone_box[b]   = '0;
            end
            mismatches = 0;
            checked    = 0;
            foreach (op_count[k]) op_count[k] = 0;
        endfunction

        function void set_weight_count(logic [WC_W-1:0] v);
            wcount = v;
        endfunction

        function int unsigned pending();
            return boxes_due.size();
        endfunction

        // lane 0 is x, 1 is y, 2 is z
        function t_box widened(t_box bx, bit was_valid, t_coord [2:0] p);
            t_box r;
            r = bx;
            for (int k = 0; k < 3; k++) begin
                if (!was_valid) begin
                    r.mn[k] = p[k];
                    r.mx[k] = p[k];
                end else begin
                    if ($signed(p[k]) < $signed(r.mn[k])) r.mn[k] = p[k];
                    if ($signed(p[k]) > $signed(r.mx[k])) r.mx[k] = p[k];
                end
            end
            return r;
        endfunction

        // an empty box reads back with zero corners
        function t_out_item box_report(bit valid, t_box bx);
            t_out_item r;
            r = '0;
            r.box_empty = !valid;
            if (valid) begin
                r.min_x = bx.mn[0];
                r.min_y = bx.mn[1];
                r.min_z = bx.mn[2];
                r.max_x = bx.mx[0];
                r.max_y = bx.mx[1];
                r.max_z = bx.mx[2];
            end
            return r;
        endfunction

        function void note_item(t_in_item it);
            t_coord [2:0] p;
            t_bone        bones [INFL_FIELDS];
            int           lim;
            op_count[it.op]++;
            p     = {it.pos_z, it.pos_y, it.pos_x};
            bones = '{it.bone_a, it.bone_b, it.bone_c, it.bone_d};
            case (t_op'(it.op))
                OP_CLEAR: begin
                    all_valid = 1'b0;
                    foreach (bone_valid[b]) bone_valid[b] = 1'b0;
                end
                OP_ADD: begin
                    all_box   = widened(all_box, all_valid, p);
                    all_valid = 1'b1;
                    lim = int'(wcount);
                    if (lim > INFL_FIELDS) lim = INFL_FIELDS;
                    if (lim > MAX_INFLUENCES) lim = MAX_INFLUENCES;
                    for (int i = 0; i < lim; i++) begin
                        if (it.weight_nonzero[i] && int'(bones[i]) < BONE_COUNT) begin
                            bone_box[bones[i]]   = widened(bone_box[bones[i]],
                                                           bone_valid[bones[i]], p);
                            bone_valid[bones[i]] = 1'b1;
                        end
                    end
                end
                OP_RD_ALL: boxes_due = {boxes_due, box_report(all_valid, all_box)};
                OP_RD_BONE: begin
                    if (int'(it.read_bone) < BONE_COUNT && bone_valid[it.read_bone])
                        boxes_due = {boxes_due, box_report(1'b1, bone_box[it.read_bone])};
                    else
                        boxes_due = {boxes_due, box_report(1'b0, '0)};
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            bit        bad;
            if (boxes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected box result: empty=%0b min=(%0d,%0d,%0d) max=(%0d,%0d,%0d)",
                             got.box_empty, got.min_x, got.min_y, got.min_z,
                             got.max_x, got.max_y, got.max_z);
                return;
            end
            want = boxes_due.pop_front();
            checked++;
            bad = (got.box_empty !== want.box_empty) ||
                  (got.min_x !== want.min_x) || (got.min_y !== want.min_y) ||
                  (got.min_z !== want.min_z) || (got.max_x !== want.max_x) ||
                  (got.max_y !== want.max_y) || (got.max_z !== want.max_z);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("box mismatch on result %0d", checked);
                    $display("  expected empty=%0b min=(%0d,%0d,%0d) max=(%0d,%0d,%0d)",
                             want.box_empty, want.min_x, want.min_y, want.min_z,
                             want.max_x, want.max_y, want.max_z);
                    $display("  actual   empty=%0b min=(%0d,%0d,%0d) max=(%0d,%0d,%0d)",
                             got.box_empty, got.min_x, got.min_y, got.min_z,
                             got.max_x, got.max_y, got.max_z);
                end
            end
        endfunction

    endclass

endpackage

// ===== sim/testbench.sv =====
// testbench for the per-bone bounding box accumulator: directed and random items
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import pbba_pkg::*;
    import bbox_check_pkg::*;

    localparam int          CYCLE_LIMIT      = 200000;
    localparam int          IDLE_SETTLE      = 16;
    localparam int          DRAIN_CYCLES     = 20;
    localparam int          RANDOM_PER_PHASE = 210;
    localparam logic [CFG_AW-1:0] ADDR_WEIGHT_COUNT = CFG_AW'(0);
    localparam t_coord      COORD_MIN        = 32'sh8000_0000;
    localparam t_coord      COORD_MAX        = 32'sh7FFF_FFFF;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_in_item          i_item;
    logic              o_result_valid;
    t_out_item         o_result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    bbox_scoreboard sb = new();
    int unsigned    reg_errors = 0;
    int unsigned    cycles = 0;
    int unsigned    settings_used = 1;

    per_bone_bounding_box_accumulator_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_in_item pack_item(t_op op, t_coord x, t_coord y, t_coord z,
                                           t_bone a, t_bone b, t_bone c, t_bone d,
                                           logic [INFL_FIELDS-1:0] w, t_bone rb);
        t_in_item it;
        it.op             = op;
        it.pos_x          = x;
        it.pos_y          = y;
        it.pos_z          = z;
        it.bone_a         = a;
        it.bone_b         = b;
        it.bone_c         = c;
        it.bone_d         = d;
        it.weight_nonzero = w;
        it.read_bone      = rb;
        return it;
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 9))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
            3, 4, 5: return t_coord'($urandom_range(0, 8191)) - 32'sd4096;
            default: return t_coord'($urandom());
        endcase
    endfunction

    // mostly a small pool of bones so that boxes grow and reads hit them
    function automatic t_bone rand_bone();
        if ($urandom_range(0, 9) < 7) return t_bone'($urandom_range(0, 7));
        return t_bone'($urandom_range(0, BONE_COUNT - 1));
    endfunction

    // keep start high when the next item follows straight after this one
    task automatic send_item(input t_in_item it, input bit hold_start);
        if (!start) start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_item(it);
        if (!hold_start) start <= 1'b0;
    endtask

    task automatic set_weight_count(input logic [WC_W-1:0] v);
        logic [CFG_DW-1:0] wdata;
        wdata = $urandom();
        wdata[WC_W-1:0] = v;
        // an add gives no result, so allow it time to finish
        while (sb.pending() != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WEIGHT_COUNT;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata[WC_W-1:0] !== v) begin
            reg_errors++;
            $display("weight count read back %0d after writing %0d", prdata[WC_W-1:0], v);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_weight_count(v);
        settings_used++;
    endtask

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles with %0d results awaited", cycles, sb.pending());
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_result_valid === 1'b1) sb.check_result(o_result);
        end
    end

    initial begin
        t_in_item          plan [$];
        logic [WC_W-1:0]   wc_plan [$];
        t_in_item          it;
        t_op               op;
        int                left;
        int                burst;
        int                gap;
        int                r;
        bit                hold;

        start   <= 1'b0;
        i_item  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty boxes after reset, extremes, repeated bone, zero weights, clear
        plan = {plan, pack_item(OP_RD_ALL, 0, 0, 0, 0, 0, 0, 0, 4'h0, 0)};
        plan = {plan, pack_item(OP_RD_BONE, 0, 0, 0, 0, 0, 0, 0, 4'h0, 0)};
        plan = {plan, pack_item(OP_RD_BONE, 0, 0, 0, 0, 0, 0, 0, 4'h0, 63)};
        plan = {plan, pack_item(OP_ADD, COORD_MIN, COORD_MAX, 0, 0, 63, 0, 5, 4'hF, 0)};
        plan = {plan, pack_item(OP_RD_ALL, 0, 0, 0, 0, 0, 0, 0, 4'h0, 0)};
        plan = {plan, pack_item(OP_RD_BONE, 0, 0, 0, 0, 0, 0, 0, 4'h0, 0)};
        plan = {plan, pack_item(OP_RD_BONE, 0, 0, 0, 0, 0, 0, 0, 4'h0, 63)};
        plan = {plan, pack_item(OP_RD_BONE, 0, 0, 0, 0, 0, 0, 0, 4'h0, 5)};
        plan = {plan, pack_item(OP_ADD, COORD_MAX, COORD_MIN, -1, 1, 2, 3, 4, 4'h0, 0)};
        plan = {plan, pack_item(OP_RD_ALL, 0, 0, 0, 0, 0, 0, 0, 4'h0, 0)};
        plan = {plan, pack_item(OP_RD_BONE, 0, 0, 0, 0, 0, 0, 0, 4'h0, 1)};
        plan = {plan, pack_item(OP_ADD, 1, 2, 3, 10, 11, 12, 13, 4'hA, 0)};
        plan = {plan, pack_item(OP_RD_BONE, 0, 0, 0, 0, 0, 0, 0, 4'h0, 11)};
        plan = {plan, pack_item(OP_RD_BONE, 0, 0, 0, 0, 0, 0, 0, 4'h0, 12)};
        plan = {plan, pack_item(OP_RD_BONE, 0, 0, 0, 0, 0, 0, 0, 4'h0, 13)};
        plan = {plan, pack_item(OP_ADD, -5, 7, COORD_MIN, 0, 0, 0, 0, 4'h1, 0)};
        plan = {plan, pack_item(OP_RD_BONE, 0, 0, 0, 0, 0, 0, 0, 4'h0, 0)};
        plan = {plan, pack_item(OP_CLEAR, -1, -1, -1, 63, 63, 63, 63, 4'hF, 63)};
        plan = {plan, pack_item(OP_RD_ALL, 0, 0, 0, 0, 0, 0, 0, 4'h0, 0)};
        plan = {plan, pack_item(OP_RD_BONE, 0, 0, 0, 0, 0, 0, 0, 4'h0, 0)};
        plan = {plan, pack_item(OP_RD_BONE, 0, 0, 0, 0, 0, 0, 0, 4'h0, 13)};
        plan = {plan, pack_item(OP_ADD, 9, -9, 0, 63, 0, 0, 0, 4'h1, 0)};
        plan = {plan, pack_item(OP_RD_ALL, 0, 0, 0, 0, 0, 0, 0, 4'h0, 0)};
        plan = {plan, pack_item(OP_RD_BONE, 0, 0, 0, 0, 0, 0, 0, 4'h0, 63)};
        foreach (plan[i]) send_item(plan[i], i != plan.size() - 1);

        // weight counts from none to above the influence limit
        wc_plan = '{3'd0, 3'd7, 3'd1, 3'd4, 3'd2, 3'd6, 3'd3, 3'd5};
        foreach (wc_plan[ph]) begin
            set_weight_count(wc_plan[ph]);
            left = RANDOM_PER_PHASE;
            while (left > 0) begin
                burst = $urandom_range(1, 24);
                if (burst > left) burst = left;
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                for (int j = 0; j < burst; j++) begin
                    r = $urandom_range(0, 99);
                    if (r < 4)       op = OP_CLEAR;
                    else if (r < 56) op = OP_ADD;
                    else if (r < 72) op = OP_RD_ALL;
                    else             op = OP_RD_BONE;
                    it = pack_item(op, rand_coord(), rand_coord(), rand_coord(),
                                   rand_bone(), rand_bone(), rand_bone(), rand_bone(),
                                   4'($urandom_range(0, 15)), rand_bone());
                    hold = (j < burst - 1) || (gap == 0 && left > 1);
                    send_item(it, hold);
                    left--;
                end
                repeat (gap) @(posedge i_clk);
            end
        end

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d clears, %0d vertices, %0d overall reads, %0d bone reads",
                 sb.op_count[OP_CLEAR], sb.op_count[OP_ADD],
                 sb.op_count[OP_RD_ALL], sb.op_count[OP_RD_BONE]);
        $display("over %0d weight count settings: %0d results checked, %0d mismatches",
                 settings_used, sb.checked, sb.mismatches + reg_errors);
        if (sb.mismatches == 0 && reg_errors == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/pbba_pkg.sv
hw/rtl/pbba_widen.sv
hw/rtl/pbba_box_mem.sv
hw/rtl/pbba_cfg.sv
hw/rtl/per_bone_bounding_box_accumulator_top.sv
sim/bbox_scoreboard_pkg.sv
sim/testbench.sv
